[rtl/rbst_pkg.sv]
// Package for the ray box slab test: field widths and the per-axis slab record.
package rbst_pkg;

	localparam int unsigned CoordW = 32;
	localparam int unsigned DiffW  = CoordW + 1;
	localparam int unsigned MulW   = DiffW + 1;
	localparam int unsigned ProdW  = 2 * MulW;
	localparam int unsigned NumAxes = 3;
	localparam int unsigned InDataW = 12 * CoordW;
	localparam int unsigned OutDataW = 8;

	// Slab of one axis: parameters a/d and b/d with a <= b, d > 0 unless dzero is set
	typedef struct packed {
		logic                    dzero;
		logic                    in_ext;
		logic signed [DiffW-1:0] a;
		logic signed [DiffW-1:0] b;
		logic [CoordW-1:0]       d;
	} slab_t;

endpackage

[rtl/rbst_axis.sv]
// Two-stage per-axis front end: corner offsets, direction sign fold and ordering.
module rbst_axis (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [rbst_pkg::CoordW-1:0]   origin,
	input  logic signed [rbst_pkg::CoordW-1:0]   dir,
	input  logic signed [rbst_pkg::CoordW-1:0]   box_min,
	input  logic signed [rbst_pkg::CoordW-1:0]   box_max,
	output rbst_pkg::slab_t                      slab
);
	import rbst_pkg::*;

	logic signed [DiffW-1:0] n0_s1, n1_s1;
	logic                    dneg_s1, dzero_s1;
	logic [CoordW-1:0]       dabs_s1;
	logic signed [DiffW-1:0] lo_c, hi_c;
	slab_t                   slab_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			n0_s1    <= DiffW'(box_min) - DiffW'(origin);
			n1_s1    <= DiffW'(box_max) - DiffW'(origin);
			dneg_s1  <= dir[CoordW-1];
			dzero_s1 <= (dir == '0);
			dabs_s1  <= dir[CoordW-1] ? CoordW'(-dir) : CoordW'(dir);
		end
	end

	assign lo_c = (n0_s1 < n1_s1) ? n0_s1 : n1_s1;
	assign hi_c = (n0_s1 < n1_s1) ? n1_s1 : n0_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			slab_s2.dzero  <= dzero_s1;
			// origin within the extent: offsets not both strictly one sign
			slab_s2.in_ext <= !(lo_c > 0 || hi_c < 0);
			slab_s2.a      <= dneg_s1 ? -hi_c : lo_c;
			slab_s2.b      <= dneg_s1 ? -lo_c : hi_c;
			slab_s2.d      <= dabs_s1;
		end
	end

	assign slab = slab_s2;

endmodule

[rtl/ray_box_slab_test_unit.sv]
// Top level of the ray box slab test: axis front ends, cross products, verdict.
// Ray / axis-aligned box slab test in signed Q16.16, one test per cycle when
// not stalled. Stages: corner offsets, sign fold and ordering, eighteen cross
// products (one 34x34 multiplier each, twelve of them used), then the pairwise
// interval compares. Slab parameters are compared as exact ratios, so grazing
// contacts count as hits and the whole line is tested. A zero direction
// component hits on that axis only when the origin lies within the box extent.
// The pipeline stalls as a whole while a result waits unread.
module ray_box_slab_test_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, box_min_x, box_min_y,
	// box_min_z, box_max_x, box_max_y, box_max_z, 32 bits each
	input  logic [rbst_pkg::InDataW-1:0]      s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// hit, then 7 zero bits
	output logic [rbst_pkg::OutDataW-1:0]     m_tdata
);
	import rbst_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;
	slab_t slab [NumAxes];
	logic signed [ProdW-1:0] pa_s3 [NumAxes][NumAxes];
	logic signed [ProdW-1:0] pb_s3 [NumAxes][NumAxes];
	logic [NumAxes-1:0] dzero_s3, in_ext_s3;
	logic hit_c, hit_s4;

	assign en       = !v_s4 || m_tready;
	assign s_tready = en;

	for (genvar ax = 0; ax < NumAxes; ax++) begin : g_axis
		rbst_axis u_axis (
			.clk     (clk),
			.en      (en),
			.origin  (s_tdata[ax*CoordW +: CoordW]),
			.dir     (s_tdata[(3+ax)*CoordW +: CoordW]),
			.box_min (s_tdata[(6+ax)*CoordW +: CoordW]),
			.box_max (s_tdata[(9+ax)*CoordW +: CoordW]),
			.slab    (slab[ax])
		);
	end

	// pa[i][j] = a_i * d_j, pb[i][j] = b_j * d_i
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NumAxes; i++) begin
				dzero_s3[i]  <= slab[i].dzero;
				in_ext_s3[i] <= slab[i].in_ext;
				for (int j = 0; j < NumAxes; j++) begin
					pa_s3[i][j] <= ProdW'($signed({slab[i].a[DiffW-1], slab[i].a})
						* $signed({2'b00, slab[j].d}));
					pb_s3[i][j] <= ProdW'($signed({slab[j].b[DiffW-1], slab[j].b})
						* $signed({2'b00, slab[i].d}));
				end
			end
		end
	end

	always_comb begin
		hit_c = 1'b1;
		for (int i = 0; i < NumAxes; i++) begin
			if (dzero_s3[i] && !in_ext_s3[i])
				hit_c = 1'b0;
			for (int j = 0; j < NumAxes; j++) begin
				if (i != j && !dzero_s3[i] && !dzero_s3[j] && pa_s3[i][j] > pb_s3[i][j])
					hit_c = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			hit_s4 <= hit_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign m_tvalid = v_s4;
	assign m_tdata  = {{(OutDataW-1){1'b0}}, hit_s4};

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted item did not enter stage one");

	a_stall_holds_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> (v_s1 == $past(v_s1)) && (v_s3 == $past(v_s3)))
		else $error("pipeline valid bits moved during a stall");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s3 |=> v_s4)
		else $error("stage three item lost on advance");

endmodule
